// File: rtl/core/bba_pkg.sv
// Shared constants, codes and helpers of the block bitmap allocator.
package bba_pkg;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned BLOCK_W  = 17;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CFG_W    = 5;
  localparam int unsigned WORD_W   = 32;

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd26;

  localparam int unsigned BLOCK_BYTES_DEF     = 4096;
  localparam int unsigned MAP_BLOCK_COUNT_DEF = 4;
  localparam int unsigned RESERVED_BLOCKS_DEF = 13;

  typedef enum logic [CMD_W-1:0] {
    CMD_FORMAT = 2'd0,
    CMD_ALLOC  = 2'd1,
    CMD_FREE   = 2'd2,
    CMD_MARK   = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_RANGE    = 2'd2
  } status_e;

  // Index of the lowest clear bit; zero when the word is all ones.
  function automatic logic [4:0] lowest_zero(input logic [WORD_W-1:0] w);
    logic [4:0] idx;
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!w[i]) idx = 5'(i);
    end
    return idx;
  endfunction

endpackage

// File: rtl/core/bba_req_if.sv
// Request channel of the block bitmap allocator.
interface bba_req_if;
  logic                        valid;
  logic                        ready;
  logic [bba_pkg::CMD_W-1:0]   command;
  logic [bba_pkg::BLOCK_W-1:0] block_in;

  modport source (output valid, output command, output block_in, input ready);
  modport sink   (input valid, input command, input block_in, output ready);
endinterface

// File: rtl/core/bba_rsp_if.sv
// Result channel of the block bitmap allocator.
interface bba_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [bba_pkg::STATUS_W-1:0] status;
  logic [bba_pkg::BLOCK_W-1:0]  block_out;

  modport source (output valid, output status, output block_out, input ready);
  modport sink   (input valid, input status, input block_out, output ready);
endinterface

// File: rtl/core/bba_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module bba_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/block_bitmap_allocator_unit.sv
// Block bitmap allocator: used/free map of disk blocks held in RAM.
//
// Requests arrive on req_i (command, block_in) with a valid/ready handshake;
// each request gives exactly one result on rsp_o (status, block_out).
// The disk size register (log2 bytes) is written through cfg_we_i/cfg_wdata_i;
// the user must do so only while no request is in flight, unchecked by the block.
// After reset all MAP_WORDS map words (4096 at the default sizes) are swept
// clean, one word a cycle, while req_i.ready stays low.
// One request is handled at a time; what each command does:
//   free / mark used : one map and one summary read, then both written back;
//                      a block out of range gives ST_RANGE, map untouched
//   allocate         : a scan of the per-summary-word full flags,
//                      32 flags a cycle, then one summary and one map read
//   format           : one map word written each cycle
// A finished result sits in the output register; the next request is taken
// while it waits. If the receiver stalls, the following result is held back
// until the register frees, and req_i.ready stays low meanwhile.
module block_bitmap_allocator_unit #(
  parameter int unsigned BLOCK_BYTES     = bba_pkg::BLOCK_BYTES_DEF,
  parameter int unsigned MAP_BLOCK_COUNT = bba_pkg::MAP_BLOCK_COUNT_DEF,
  parameter int unsigned RESERVED_BLOCKS = bba_pkg::RESERVED_BLOCKS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bba_pkg::CFG_W-1:0]   cfg_wdata_i,
  bba_req_if.sink                     req_i,
  bba_rsp_if.source                   rsp_o
);

  localparam int unsigned MAP_BITS  = MAP_BLOCK_COUNT * BLOCK_BYTES * 8;
  localparam int unsigned MAP_WORDS = MAP_BITS / 32;
  localparam int unsigned WA_W      = $clog2(MAP_WORDS);
  localparam int unsigned SUM_WORDS = MAP_WORDS / 32;
  localparam int unsigned SA_W      = $clog2(SUM_WORDS);
  localparam int unsigned CHUNKS    = (SUM_WORDS + 31) / 32;
  localparam int unsigned CH_W      = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int unsigned CNT_W     = $clog2(MAP_BITS + 1);
  localparam int unsigned BB_LOG2   = $clog2(BLOCK_BYTES);
  localparam int unsigned XW        = ((CNT_W > bba_pkg::BLOCK_W) ? CNT_W
                                                                 : bba_pkg::BLOCK_W) + 1;
  localparam logic [31:0] ONES      = 32'hFFFF_FFFF;
  localparam logic [31:0] RES_MASK  = ~(ONES >> RESERVED_BLOCKS);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_FORMAT, S_SCAN, S_SUM, S_MAP, S_BIT, S_EMIT
  } state_e;

  state_e                         state_q;
  logic [WA_W-1:0]                wc_q;
  logic [30:0]                    acc_q;
  logic [CH_W-1:0]                chunk_q;
  logic [SUM_WORDS-1:0]           l2_q;
  logic [bba_pkg::CFG_W-1:0]      cfg_q;
  logic                           free_q;
  logic [WA_W-1:0]                w_q;
  logic [SA_W-1:0]                s_q;
  logic [31:0]                    sum_q;
  bba_pkg::status_e               res_status_q;
  logic [bba_pkg::BLOCK_W-1:0]    res_block_q;
  logic                           out_vld_q;
  bba_pkg::status_e               out_status_q;
  logic [bba_pkg::BLOCK_W-1:0]    out_block_q;

  logic              map_we, map_re, sum_we, sum_re;
  logic [WA_W-1:0]   map_waddr, map_raddr;
  logic [SA_W-1:0]   sum_waddr, sum_raddr;
  logic [31:0]       map_wdata, map_rdata, sum_wdata, sum_rdata;

  logic                accept, out_free, in_range;
  logic [CNT_W-1:0]    disk_count;
  logic [4:0]          sh;
  logic [CNT_W-1:0]    pw;
  logic [XW-1:0]       base, count_x;
  logic [31:0]         fmt_word, word_val;
  logic                word_full, grp_end, wc_last;
  logic [CHUNKS*32-1:0] l2_pad;
  logic [31:0]         chunk;
  logic                chunk_open;
  logic [SA_W-1:0]     scan_s;
  logic [4:0]          alloc_pos;
  logic [31:0]         alloc_word, alloc_sum;
  logic                alloc_full;
  logic [31:0]         bit_mask, bit_word, bit_sum;
  logic                bit_full;
  logic [SA_W-1:0]     w_sum;

  assign accept   = req_i.valid && req_i.ready;
  assign out_free = !out_vld_q || rsp_o.ready;
  assign req_i.ready     = (state_q == S_IDLE);
  assign rsp_o.valid     = out_vld_q;
  assign rsp_o.status    = out_status_q;
  assign rsp_o.block_out = out_block_q;

  // Disk block count, limited to what the map holds.
  always_comb begin
    sh = '0;
    pw = '0;
    disk_count = '0;
    if (cfg_q >= 5'(BB_LOG2)) begin
      sh = cfg_q - 5'(BB_LOG2);
      if (sh >= 5'(CNT_W)) begin
        disk_count = CNT_W'(MAP_BITS);
      end else begin
        pw = CNT_W'(1) << sh;
        disk_count = (pw > CNT_W'(MAP_BITS)) ? CNT_W'(MAP_BITS) : pw;
      end
    end
  end

  assign in_range = XW'(req_i.block_in) < XW'(disk_count);

  // Format word: reserved blocks in word 0, everything past the disk end used.
  assign base    = XW'({wc_q, 5'b0});
  assign count_x = XW'(disk_count);
  always_comb begin
    if (count_x >= base + XW'(32)) fmt_word = '0;
    else if (count_x <= base)     fmt_word = ONES;
    else                          fmt_word = ONES >> 5'(count_x - base);
    if (wc_q == '0) fmt_word = fmt_word | RES_MASK;
  end

  assign word_val  = (state_q == S_CLEAR) ? '0 : fmt_word;
  assign word_full = (word_val == ONES);
  assign grp_end   = (wc_q[4:0] == 5'd31);
  assign wc_last   = (wc_q == WA_W'(MAP_WORDS - 1));

  // Full-flag scan, 32 summary words a cycle; padding reads as full.
  always_comb begin
    l2_pad = '1;
    l2_pad[SUM_WORDS-1:0] = l2_q;
  end
  assign chunk      = l2_pad[chunk_q*32 +: 32];
  assign chunk_open = (chunk != ONES);
  assign scan_s     = SA_W'({chunk_q, bba_pkg::lowest_zero(chunk)});

  assign alloc_pos  = bba_pkg::lowest_zero(map_rdata);
  assign alloc_word = map_rdata | (32'b1 << alloc_pos);
  assign alloc_full = (alloc_word == ONES);
  assign alloc_sum  = sum_q | (32'b1 << w_q[4:0]);

  assign w_sum    = SA_W'(w_q >> 5);
  assign bit_mask = 32'h8000_0000 >> res_block_q[4:0];
  assign bit_word = free_q ? (map_rdata & ~bit_mask) : (map_rdata | bit_mask);
  assign bit_full = (bit_word == ONES);
  assign bit_sum  = (sum_rdata & ~(32'b1 << w_q[4:0])) | (32'(bit_full) << w_q[4:0]);

  // RAM control. Reads and writes never fall in the same cycle, so no
  // forwarding is needed.
  always_comb begin
    map_we = 1'b0; map_waddr = w_q; map_wdata = alloc_word;
    map_re = 1'b0; map_raddr = WA_W'(req_i.block_in >> 5);
    sum_we = 1'b0; sum_waddr = w_sum; sum_wdata = alloc_sum;
    sum_re = 1'b0; sum_raddr = SA_W'(req_i.block_in >> 10);
    case (state_q)
      S_CLEAR, S_FORMAT: begin
        map_we    = 1'b1;
        map_waddr = wc_q;
        map_wdata = word_val;
        sum_we    = grp_end;
        sum_waddr = SA_W'(wc_q >> 5);
        sum_wdata = {word_full, acc_q};
      end
      S_IDLE: begin
        map_re = accept && (req_i.command == bba_pkg::CMD_FREE
                            || req_i.command == bba_pkg::CMD_MARK);
        sum_re = map_re;
      end
      S_SCAN: begin
        sum_re    = chunk_open;
        sum_raddr = scan_s;
      end
      S_SUM: begin
        map_re    = 1'b1;
        map_raddr = WA_W'({s_q, bba_pkg::lowest_zero(sum_rdata)});
      end
      S_MAP: begin
        map_we = 1'b1;
        sum_we = alloc_full;
      end
      S_BIT: begin
        map_we    = 1'b1;
        map_wdata = bit_word;
        sum_we    = 1'b1;
        sum_wdata = bit_sum;
      end
      default: ;
    endcase
  end

  bba_ram #(.WIDTH(32), .DEPTH(MAP_WORDS)) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .re_i    (map_re),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata)
  );

  // One bit per map word, set when that word is full.
  bba_ram #(.WIDTH(32), .DEPTH(SUM_WORDS)) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (sum_we),
    .waddr_i (sum_waddr),
    .wdata_i (sum_wdata),
    .re_i    (sum_re),
    .raddr_i (sum_raddr),
    .rdata_o (sum_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      wc_q         <= '0;
      acc_q        <= '0;
      chunk_q      <= '0;
      l2_q         <= '0;
      cfg_q        <= bba_pkg::CFG_RESET;
      free_q       <= 1'b0;
      w_q          <= '0;
      s_q          <= '0;
      sum_q        <= '0;
      res_status_q <= bba_pkg::ST_OK;
      res_block_q  <= '0;
      out_vld_q    <= 1'b0;
      out_status_q <= bba_pkg::ST_OK;
      out_block_q  <= '0;
    end else begin
      if (cfg_we_i) cfg_q <= cfg_wdata_i;
      if (rsp_o.valid && rsp_o.ready && state_q != S_EMIT) out_vld_q <= 1'b0;

      case (state_q)
        S_CLEAR, S_FORMAT: begin
          if (grp_end) l2_q[SA_W'(wc_q >> 5)] <= ({word_full, acc_q} == ONES);
          else         acc_q[wc_q[4:0]] <= word_full;
          if (wc_last) begin
            wc_q <= '0;
            if (state_q == S_CLEAR) begin
              state_q <= S_IDLE;
            end else begin
              res_status_q <= bba_pkg::ST_OK;
              res_block_q  <= '0;
              state_q      <= S_EMIT;
            end
          end else begin
            wc_q <= wc_q + WA_W'(1);
          end
        end
        S_IDLE: begin
          if (accept) begin
            free_q      <= (req_i.command == bba_pkg::CMD_FREE);
            w_q         <= WA_W'(req_i.block_in >> 5);
            res_block_q <= req_i.block_in;
            case (bba_pkg::cmd_e'(req_i.command))
              bba_pkg::CMD_FORMAT: begin
                wc_q    <= '0;
                state_q <= S_FORMAT;
              end
              bba_pkg::CMD_ALLOC: begin
                chunk_q <= '0;
                state_q <= S_SCAN;
              end
              default: begin
                if (in_range) begin
                  state_q <= S_BIT;
                end else begin
                  res_status_q <= bba_pkg::ST_RANGE;
                  res_block_q  <= '0;
                  state_q      <= S_EMIT;
                end
              end
            endcase
          end
        end
        S_SCAN: begin
          if (chunk_open) begin
            s_q     <= scan_s;
            state_q <= S_SUM;
          end else if (chunk_q == CH_W'(CHUNKS - 1)) begin
            res_status_q <= bba_pkg::ST_NO_SPACE;
            res_block_q  <= '0;
            state_q      <= S_EMIT;
          end else begin
            chunk_q <= chunk_q + CH_W'(1);
          end
        end
        S_SUM: begin
          sum_q   <= sum_rdata;
          w_q     <= WA_W'({s_q, bba_pkg::lowest_zero(sum_rdata)});
          state_q <= S_MAP;
        end
        S_MAP: begin
          if (alloc_full) l2_q[w_sum] <= (alloc_sum == ONES);
          res_status_q <= bba_pkg::ST_OK;
          res_block_q  <= bba_pkg::BLOCK_W'({w_q, ~alloc_pos});
          state_q      <= S_EMIT;
        end
        S_BIT: begin
          l2_q[w_sum]  <= (bit_sum == ONES);
          res_status_q <= bba_pkg::ST_OK;
          res_block_q  <= '0;
          state_q      <= S_EMIT;
        end
        S_EMIT: begin
          // a handshake here leaves the register free, so it is refilled at once
          if (out_free) begin
            out_vld_q    <= 1'b1;
            out_status_q <= res_status_q;
            out_block_q  <= res_block_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  // The full flags must only ever steer the search to a word with a free bit.
  a_sum_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SUM |-> sum_rdata != ONES)
    else $error("summary word picked by the scan is full");

  a_map_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MAP |-> map_rdata != ONES)
    else $error("map word picked by the summary is full");

  a_map_waddr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    map_we |-> 32'(map_waddr) < MAP_WORDS)
    else $error("map write beyond the map");

  a_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && out_free) |=> (rsp_o.valid && state_q == S_IDLE))
    else $error("result not loaded into the output register");
`endif

endmodule

// File: bench/bba_reply_check.sv
// Reply checker: shadow bitmap of the allocator, predicts every reply and compares.
module bba_reply_check import bba_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i,
  bba_req_if                req_mon_i,
  bba_rsp_if                rsp_mon_i,
  output int unsigned       fail_count_o,
  output int unsigned       pending_o,
  output int unsigned       replies_o,
  output int unsigned       no_space_o,
  output int unsigned       range_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAP_BITS  = MAP_BLOCK_COUNT_DEF * BLOCK_BYTES_DEF * 8;
  localparam int unsigned MAP_WORDS = MAP_BITS / WORD_W;

  typedef struct packed {
    status_e              status;
    logic [BLOCK_W-1:0]   block;
  } reply_t;

  bit   [WORD_W-1:0] shadow_map [MAP_WORDS];
  logic [CFG_W-1:0]  disk_log2 = CFG_RESET;
  reply_t            awaited_replies [$];

  function automatic int unsigned block_limit();
    longint unsigned n;
    n = (64'd1 << disk_log2) / BLOCK_BYTES_DEF;
    return (n > MAP_BITS) ? MAP_BITS : int'(n);
  endfunction

  function automatic void format_shadow();
    int unsigned lim;
    int unsigned base;
    lim = block_limit();
    for (int unsigned w = 0; w < MAP_WORDS; w++) begin
      base = w * WORD_W;
      if (base >= lim) begin
        shadow_map[w] = '1;
      end else if (base >= RESERVED_BLOCKS_DEF && base + WORD_W <= lim) begin
        shadow_map[w] = '0;
      end else begin
        // MSB of a word is its lowest block
        for (int unsigned b = 0; b < WORD_W; b++)
          shadow_map[w][WORD_W-1-b] = (base + b < RESERVED_BLOCKS_DEF) || (base + b >= lim);
      end
    end
  endfunction

  function automatic reply_t take_block();
    reply_t      r;
    int unsigned pos;
    r.status = ST_NO_SPACE;
    r.block  = '0;
    for (int unsigned w = 0; w < MAP_WORDS; w++) begin
      if (shadow_map[w] != '1) begin
        pos = 0;
        while (pos < WORD_W - 1 && shadow_map[w][pos]) pos++;
        shadow_map[w][pos] = 1'b1;
        r.status = ST_OK;
        r.block  = BLOCK_W'(w * WORD_W + WORD_W - 1 - pos);
        return r;
      end
    end
    return r;
  endfunction

  function automatic reply_t predict_reply(cmd_e c, logic [BLOCK_W-1:0] b);
    reply_t r;
    r.status = ST_OK;
    r.block  = '0;
    case (c)
      CMD_FORMAT: format_shadow();
      CMD_ALLOC:  r = take_block();
      default: begin
        if (b >= block_limit()) r.status = ST_RANGE;
        else shadow_map[b[BLOCK_W-1:5]][~b[4:0]] = (c == CMD_MARK);
      end
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    reply_t due;
    if (!rst_ni) begin
      foreach (shadow_map[i]) shadow_map[i] = '0;
      disk_log2 = CFG_RESET;
      awaited_replies.delete();
      fail_count_o = 0;
      replies_o    = 0;
      no_space_o   = 0;
      range_o      = 0;
    end else begin
      if (rsp_mon_i.valid && rsp_mon_i.ready) begin
        replies_o++;
        if (awaited_replies.size() == 0) begin
          fail_count_o++;
          $display("%0t: unexpected reply: status %0d block %0d", $time,
                   rsp_mon_i.status, rsp_mon_i.block_out);
        end else begin
          due = awaited_replies.pop_front();
          if (due.status == ST_NO_SPACE) no_space_o++;
          if (due.status == ST_RANGE) range_o++;
          if (rsp_mon_i.status !== due.status || rsp_mon_i.block_out !== due.block) begin
            fail_count_o++;
            $display("%0t: reply mismatch: expected status %0d block %0d, got status %0d block %0d",
                     $time, due.status, due.block, rsp_mon_i.status, rsp_mon_i.block_out);
          end
        end
      end
      if (req_mon_i.valid && req_mon_i.ready)
        awaited_replies.push_back(predict_reply(cmd_e'(req_mon_i.command), req_mon_i.block_in));
      if (cfg_we_i) disk_log2 = cfg_wdata_i;
    end
    pending_o = awaited_replies.size();
  end

endmodule

// File: bench/block_bitmap_allocator_unit_test.sv
// Testbench top: drives directed and random allocator requests and gives the verdict.
module block_bitmap_allocator_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import bba_pkg::*;

  localparam int unsigned MAP_BITS     = MAP_BLOCK_COUNT_DEF * BLOCK_BYTES_DEF * 8;
  localparam int unsigned PHASES       = 10;
  localparam int unsigned PHASE_ITEMS  = 200;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  bba_req_if req_ch ();
  bba_rsp_if rsp_ch ();

  int unsigned fail_count, pending, replies, no_space, out_of_range;
  int unsigned req_gap_pct, rsp_stall_pct;
  logic [CFG_W-1:0] cur_log2;

  block_bitmap_allocator_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_ch),
    .rsp_o       (rsp_ch)
  );

  bba_reply_check reply_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .req_mon_i    (req_ch),
    .rsp_mon_i    (rsp_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .replies_o    (replies),
    .no_space_o   (no_space),
    .range_o      (out_of_range)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver back-pressure
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
    end
  end

  function automatic int unsigned disk_block_count(logic [CFG_W-1:0] l);
    longint unsigned n;
    n = (64'd1 << l) / BLOCK_BYTES_DEF;
    return (n > MAP_BITS) ? MAP_BITS : int'(n);
  endfunction

  // Entered and left at a falling edge.
  task automatic send_req(cmd_e c, logic [BLOCK_W-1:0] b);
    while ($urandom_range(99) < req_gap_pct) begin
      req_ch.valid    <= 1'b0;
      req_ch.command  <= cmd_e'($urandom_range(3));
      req_ch.block_in <= BLOCK_W'($urandom);
      @(negedge clk_i);
    end
    req_ch.valid    <= 1'b1;
    req_ch.command  <= c;
    req_ch.block_in <= b;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Hold requests off until every reply is back and the block has gone quiet.
  task automatic settle();
    req_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_disk_size(logic [CFG_W-1:0] l);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= l;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    cur_log2 = l;
  endtask

  task automatic random_item();
    int unsigned lim, sel;
    logic [BLOCK_W-1:0] b;
    cmd_e c;
    lim = disk_block_count(cur_log2);
    sel = $urandom_range(99);
    if (sel < 70 && lim > 0) b = BLOCK_W'($urandom_range(lim - 1));
    else if (sel < 80) b = BLOCK_W'(lim);
    else if (sel < 85 && lim > 0) b = BLOCK_W'(lim - 1);
    else b = BLOCK_W'($urandom);
    sel = $urandom_range(199);
    if (sel < 3) c = CMD_FORMAT;
    else if (sel < 95) c = CMD_ALLOC;
    else if (sel < 155) c = CMD_FREE;
    else c = CMD_MARK;
    send_req(c, b);
  endtask

  initial begin : stimulus
    logic [CFG_W-1:0] phase_sizes [PHASES];
    int unsigned      gap_modes   [4];
    int unsigned      stall_modes [4];
    phase_sizes = '{5'd17, 5'd26, 5'd12, 5'd18, 5'd29, 5'd16, 5'd30, 5'd19, 5'd17, 5'd21};
    gap_modes   = '{0, 48, 0, 36};
    stall_modes = '{0, 0, 48, 36};
    rst_ni          = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = CFG_RESET;
    cur_log2        = CFG_RESET;
    req_ch.valid    = 1'b0;
    req_ch.command  = CMD_FORMAT;
    req_ch.block_in = '0;
    req_gap_pct     = 0;
    rsp_stall_pct   = 0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // map untouched since reset: first allocate lands on the last block of word 0
    send_req(CMD_ALLOC, '0);
    send_req(CMD_FREE, 17'd31);
    send_req(CMD_MARK, '0);
    send_req(CMD_FREE, '1);
    send_req(CMD_MARK, 17'd16384);
    send_req(CMD_MARK, 17'd16383);
    send_req(CMD_FORMAT, '0);
    send_req(CMD_ALLOC, '0);
    send_req(CMD_ALLOC, '0);
    send_req(CMD_FREE, 17'd13);
    send_req(CMD_ALLOC, '0);
    // one-block disk: map full after format
    write_disk_size(5'd12);
    send_req(CMD_FORMAT, '0);
    send_req(CMD_ALLOC, '0);
    send_req(CMD_FREE, '0);
    send_req(CMD_FREE, 17'd1);
    send_req(CMD_ALLOC, '0);
    send_req(CMD_ALLOC, '0);
    // disk smaller than a block
    write_disk_size(5'd5);
    send_req(CMD_FORMAT, '0);
    send_req(CMD_ALLOC, '0);
    send_req(CMD_FREE, '0);
    send_req(CMD_MARK, '0);
    // sizes past the map are clipped to it
    write_disk_size(5'd31);
    send_req(CMD_FORMAT, '0);
    send_req(CMD_MARK, '1);
    send_req(CMD_FREE, '1);
    send_req(CMD_ALLOC, '0);
    write_disk_size(5'd29);
    send_req(CMD_MARK, '1);

    for (int p = 0; p < PHASES; p++) begin
      req_gap_pct   = gap_modes[p % 4];
      rsp_stall_pct = stall_modes[p % 4];
      write_disk_size(phase_sizes[p]);
      send_req(CMD_FORMAT, BLOCK_W'($urandom));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == PHASE_ITEMS / 2) settle();
        random_item();
      end
    end

    settle();
    repeat (20) @(negedge clk_i);
    $display("%0d requests checked over %0d disk sizes plus the directed set;", replies, PHASES);
    $display("%0d found no free block, %0d had a block out of range", no_space, out_of_range);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("timeout with %0d replies outstanding", pending);
    $display("TEST FAILED");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/bba_pkg.sv
rtl/core/bba_req_if.sv
rtl/core/bba_rsp_if.sv
rtl/core/bba_ram.sv
rtl/core/block_bitmap_allocator_unit.sv
bench/bba_reply_check.sv
bench/block_bitmap_allocator_unit_test.sv
